FILE: rtl/cbc_pkg.sv
// Package with the shared types and constants of the cartridge bank controller.
package cbc_pkg;

	// Controller kinds selected by the controller type register (REG_CTL_TYPE).
	typedef enum logic [1:0] {
		CTL_NONE = 2'd0,
		CTL_MBC1 = 2'd1,
		CTL_MBC2 = 2'd2,
		CTL_MBC3 = 2'd3
	} ctl_type_t;

	// Banking mode codes as they appear on bank_mode.
	localparam logic [1:0] MODE_ROM = 2'd0;
	localparam logic [1:0] MODE_RAM = 2'd1;
	localparam logic [1:0] MODE_RTC = 2'd2;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_CTL_TYPE  = 2'd0;
	localparam logic [1:0] REG_ROM_TOTAL = 2'd1;
	localparam logic [1:0] REG_RAM_TOTAL = 2'd2;
	localparam logic [1:0] REG_RAM_SIZE  = 2'd3;

	// Header RAM size codes that matter to the write window.
	localparam logic [1:0] RAM_SIZE_NONE = 2'd0;
	localparam logic [1:0] RAM_SIZE_2K   = 2'd1;

	// Address regions, taken from address bits 15:13.
	localparam logic [2:0] REGION_ENABLE = 3'd0;
	localparam logic [2:0] REGION_ROM_LO = 3'd1;
	localparam logic [2:0] REGION_UPPER  = 3'd2;
	localparam logic [2:0] REGION_MODE   = 3'd3;
	localparam logic [2:0] REGION_RAM    = 3'd5;

	// Data nibble that enables external RAM.
	localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

	// Configuration register set.
	typedef struct packed {
		ctl_type_t   ctl_type;
		logic [8:0]  rom_bank_total;
		logic [2:0]  ram_bank_total;
		logic [1:0]  ram_size_code;
	} cbc_cfg_t;

	// One result transaction.
	typedef struct packed {
		logic [7:0]  rom_bank;
		logic [1:0]  ram_bank;
		logic        ram_on;
		logic [1:0]  bank_mode;
		logic        ram_write;
		logic [14:0] ram_address;
		logic [7:0]  write_value;
		logic        rtc_write;
		logic [2:0]  rtc_index;
	} cbc_result_t;

endpackage

FILE: rtl/cbc_cfg_regs.sv
// APB-style configuration register file of the cartridge bank controller.
module cbc_cfg_regs
	import cbc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cbc_cfg_t    cfg
);

	cbc_cfg_t   cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// Register writes on the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ctl_type       <= CTL_NONE;
			cfg_q.rom_bank_total <= 9'd0;
			cfg_q.ram_bank_total <= 3'd0;
			cfg_q.ram_size_code  <= 2'd0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_CTL_TYPE:  cfg_q.ctl_type       <= ctl_type_t'(pwdata[1:0]);
				REG_ROM_TOTAL: cfg_q.rom_bank_total <= pwdata[8:0];
				REG_RAM_TOTAL: cfg_q.ram_bank_total <= pwdata[2:0];
				REG_RAM_SIZE:  cfg_q.ram_size_code  <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// Read data multiplexer.
	always_comb begin
		case (reg_idx)
			REG_CTL_TYPE:  prdata = {30'd0, cfg_q.ctl_type};
			REG_ROM_TOTAL: prdata = {23'd0, cfg_q.rom_bank_total};
			REG_RAM_TOTAL: prdata = {29'd0, cfg_q.ram_bank_total};
			REG_RAM_SIZE:  prdata = {30'd0, cfg_q.ram_size_code};
			default:       prdata = 32'd0;
		endcase
	end

endmodule

FILE: rtl/cbc_core.sv
// Bank register state and the write decode that updates it and forms each result.
module cbc_core
	import cbc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cbc_cfg_t    cfg,
	input  logic        step,
	input  logic [15:0] addr,
	input  logic [7:0]  data,
	output cbc_result_t result
);

	logic [7:0] rom_bank_q;
	logic [1:0] ram_bank_q;
	logic       ram_enable_q;
	logic [1:0] mode_q;
	logic [2:0] rtc_select_q;

	logic [7:0]  rom_bank_d;
	logic [1:0]  ram_bank_d;
	logic        ram_enable_d;
	logic [1:0]  mode_d;
	logic [2:0]  rtc_select_d;
	logic        rw;
	logic        tw;
	logic [14:0] raddr;
	logic [7:0]  wval;

	logic [2:0]  region;
	logic [12:0] off;
	logic        en_key;
	logic        low_window;
	logic        rom_multi;
	logic [7:0]  rom_req;
	logic        rom_set;
	logic [1:0]  ram_req;
	logic        ram_set;

	assign region     = addr[15:13];
	assign off        = addr[12:0];
	assign en_key     = (data[3:0] == RAM_ENABLE_KEY);
	assign low_window = (addr[12:11] == 2'b00);
	assign rom_multi  = (cfg.rom_bank_total > 9'd1);

	// Decode of one write access and the next register values.
	always_comb begin
		rom_req      = rom_bank_q;
		rom_set      = 1'b0;
		ram_req      = ram_bank_q;
		ram_set      = 1'b0;
		ram_enable_d = ram_enable_q;
		mode_d       = mode_q;
		rtc_select_d = rtc_select_q;
		rw           = 1'b0;
		tw           = 1'b0;
		raddr        = 15'd0;
		wval         = 8'd0;

		case (cfg.ctl_type)
			CTL_NONE: begin
				if (region == REGION_RAM) begin
					if (cfg.ram_size_code == RAM_SIZE_2K) begin
						if (low_window) begin
							rw    = 1'b1;
							raddr = {2'b00, off};
							wval  = data;
						end
					end else if (cfg.ram_size_code != RAM_SIZE_NONE) begin
						rw    = 1'b1;
						raddr = {2'b00, off};
						wval  = data;
					end
				end
			end
			CTL_MBC1: begin
				case (region)
					REGION_ENABLE: ram_enable_d = en_key;
					REGION_ROM_LO: begin
						rom_set = rom_multi;
						rom_req = {1'b0, rom_bank_q[6:5],
							(data[4:0] == 5'd0) ? 5'd1 : data[4:0]};
					end
					REGION_UPPER: begin
						if (mode_q == MODE_ROM && rom_multi) begin
							rom_set = 1'b1;
							rom_req = {1'b0, data[1:0], rom_bank_q[4:0]};
						end else if (mode_q == MODE_RAM && cfg.ram_bank_total > 3'd1) begin
							ram_set = 1'b1;
							ram_req = data[1:0];
						end
					end
					REGION_MODE: mode_d = (data == 8'h01) ? MODE_RAM : MODE_ROM;
					REGION_RAM: begin
						if (ram_enable_q && cfg.ram_bank_total != 3'd0 &&
							((cfg.ram_size_code > RAM_SIZE_2K) ||
							 (cfg.ram_size_code == RAM_SIZE_2K && low_window))) begin
							rw    = 1'b1;
							raddr = {ram_bank_q, off};
							wval  = data;
						end
					end
					default: ;
				endcase
			end
			CTL_MBC2: begin
				case (region)
					REGION_ENABLE: begin
						if (!addr[8]) ram_enable_d = en_key;
					end
					REGION_ROM_LO: begin
						rom_set = addr[8];
						rom_req = {4'd0, (data[3:0] == 4'd0) ? 4'd1 : data[3:0]};
					end
					REGION_RAM: begin
						// Built-in RAM covers only the first 512 bytes of the window.
						if (off[12:9] == 4'd0 && ram_enable_q) begin
							rw    = 1'b1;
							raddr = {2'b00, off};
							wval  = {4'd0, data[3:0]};
						end
					end
					default: ;
				endcase
			end
			default: begin
				case (region)
					REGION_ENABLE: ram_enable_d = en_key;
					REGION_ROM_LO: begin
						rom_set = rom_multi;
						rom_req = {1'b0, (data[6:0] == 7'd0) ? 7'd1 : data[6:0]};
					end
					REGION_UPPER: begin
						if (data < 8'h04) begin
							mode_d  = MODE_RAM;
							ram_set = 1'b1;
							ram_req = data[1:0];
						end else if (data inside {[8'h08:8'h0C]}) begin
							mode_d       = MODE_RTC;
							rtc_select_d = data[2:0];
						end
					end
					REGION_RAM: begin
						if (mode_q == MODE_RAM && ram_enable_q) begin
							rw    = 1'b1;
							raddr = {ram_bank_q, off};
							wval  = data;
						end else if (mode_q == MODE_RTC) begin
							tw   = 1'b1;
							wval = data;
						end
					end
					default: ;
				endcase
			end
		endcase

		// Bank numbers at or above the bank count leave the bank unchanged.
		rom_bank_d = (rom_set && ({1'b0, rom_req} < cfg.rom_bank_total)) ?
			rom_req : rom_bank_q;
		ram_bank_d = (ram_set && ({1'b0, ram_req} < cfg.ram_bank_total)) ?
			ram_req : ram_bank_q;
	end

	// Bank state advances once per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q   <= 8'd1;
			ram_bank_q   <= 2'd0;
			ram_enable_q <= 1'b0;
			mode_q       <= MODE_ROM;
			rtc_select_q <= 3'd0;
		end else if (step) begin
			rom_bank_q   <= rom_bank_d;
			ram_bank_q   <= ram_bank_d;
			ram_enable_q <= ram_enable_d;
			mode_q       <= mode_d;
			rtc_select_q <= rtc_select_d;
		end
	end

	// The result shows the mapping as it stands after this write.
	always_comb begin
		result.rom_bank    = rom_bank_d;
		result.ram_bank    = ram_bank_d;
		result.ram_on      = ram_enable_d;
		result.bank_mode   = mode_d;
		result.ram_write   = rw;
		result.ram_address = raddr;
		result.write_value = wval;
		result.rtc_write   = tw;
		result.rtc_index   = rtc_select_d;
	end

endmodule

FILE: rtl/cartridge_bank_controller.sv
// Cartridge bank controller top level: input register, decode core and result register.
// An accepted write is held in the input register, its result then in the result register.
// Throughput: one transaction per cycle while out_stall is low; the input register and
// the result register let a new transaction enter while a finished result waits to be taken.
// Reset: arst_n clears the bank state to ROM bank 1, RAM bank 0, RAM disabled,
// ROM mode, RTC register 0, and all configuration registers to zero.
module cartridge_bank_controller
	import cbc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] bus_address,
	input  logic [7:0]  bus_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  rom_bank,
	output logic [1:0]  ram_bank,
	output logic        ram_on,
	output logic [1:0]  bank_mode,
	output logic        ram_write,
	output logic [14:0] ram_address,
	output logic [7:0]  write_value,
	output logic        rtc_write,
	output logic [2:0]  rtc_index
);

	cbc_cfg_t    cfg;
	cbc_result_t result;
	cbc_result_t result_s2;
	logic        valid_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;
	logic        valid_s2;
	logic        advance;
	logic        accept;

	cbc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The stage-1 transaction moves on when the result register is free or drains.
	assign advance  = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~advance;
	assign accept   = in_valid & ~in_stall;

	cbc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.addr   (addr_s1),
		.data   (data_s1),
		.result (result)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= bus_address;
			data_s1 <= bus_data;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid   = valid_s2;
	assign rom_bank    = result_s2.rom_bank;
	assign ram_bank    = result_s2.ram_bank;
	assign ram_on      = result_s2.ram_on;
	assign bank_mode   = result_s2.bank_mode;
	assign ram_write   = result_s2.ram_write;
	assign ram_address = result_s2.ram_address;
	assign write_value = result_s2.write_value;
	assign rtc_write   = result_s2.rtc_write;
	assign rtc_index   = result_s2.rtc_index;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the cartridge bank controller, with its scoreboard and stimulus.
`timescale 1ns / 1ps

import cbc_pkg::*;

// Keeps its own copy of the bank state, predicts each result and checks what arrives.
class bank_scoreboard;
	cbc_cfg_t    cfg;
	logic [7:0]  rom_bank_q;
	logic [1:0]  ram_bank_q;
	logic        ram_on_q;
	logic [1:0]  mode_q;
	logic [2:0]  rtc_sel_q;
	cbc_result_t expected_q[$];
	int          mismatches;

	function new();
		cfg = '0;
		rom_bank_q = 8'd1;
		ram_bank_q = 2'd0;
		ram_on_q = 1'b0;
		mode_q = MODE_ROM;
		rtc_sel_q = 3'd0;
		mismatches = 0;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	// Mirrors a register write on the configuration port.
	function void write_register(logic [1:0] idx, logic [31:0] value);
		case (idx)
			REG_CTL_TYPE:  cfg.ctl_type = ctl_type_t'(value[1:0]);
			REG_ROM_TOTAL: cfg.rom_bank_total = value[8:0];
			REG_RAM_TOTAL: cfg.ram_bank_total = value[2:0];
			default:       cfg.ram_size_code = value[1:0];
		endcase
	endfunction

	// A bank number at or above the bank count leaves the register alone.
	function void load_rom_bank(logic [7:0] bank);
		if ({1'b0, bank} < cfg.rom_bank_total)
			rom_bank_q = bank;
	endfunction

	function void load_ram_bank(logic [1:0] bank);
		if ({1'b0, bank} < cfg.ram_bank_total)
			ram_bank_q = bank;
	endfunction

	// Applies one accepted write transaction and queues the mapping it leaves behind.
	function void note_access(logic [15:0] a, logic [7:0] d);
		logic        in_ram;
		logic [12:0] off;
		logic        en;
		logic        rw;
		logic        tw;
		logic [14:0] raddr;
		logic [7:0]  wval;
		logic [7:0]  low;
		cbc_result_t r;
		in_ram = (a[15:13] == REGION_RAM);
		off = a[12:0];
		en = (d[3:0] == RAM_ENABLE_KEY);
		rw = 1'b0;
		tw = 1'b0;
		raddr = '0;
		wval = '0;
		case (cfg.ctl_type)
			CTL_NONE: begin
				// No controller: the size code alone decides the write window.
				if (in_ram) begin
					if (cfg.ram_size_code == RAM_SIZE_2K) begin
						if (a < 16'hA800) begin
							rw = 1'b1;
							raddr = {2'b00, off};
							wval = d;
						end
					end else if (cfg.ram_size_code != RAM_SIZE_NONE) begin
						rw = 1'b1;
						raddr = {2'b00, off};
						wval = d;
					end
				end
			end
			CTL_MBC1: begin
				case (a[15:13])
					REGION_ENABLE: ram_on_q = en;
					REGION_ROM_LO: begin
						if (cfg.rom_bank_total > 9'd1) begin
							low = (d[4:0] == 5'd0) ? 8'd1 : {3'b000, d[4:0]};
							load_rom_bank((rom_bank_q & 8'h60) | low);
						end
					end
					REGION_UPPER: begin
						// Upper bits go to the ROM bank in ROM mode, to the RAM bank in RAM mode.
						if (mode_q == MODE_ROM && cfg.rom_bank_total > 9'd1)
							load_rom_bank({1'b0, d[1:0], rom_bank_q[4:0]});
						else if (mode_q == MODE_RAM && cfg.ram_bank_total > 3'd1)
							load_ram_bank(d[1:0]);
					end
					REGION_MODE: mode_q = (d == 8'h01) ? MODE_RAM : MODE_ROM;
					REGION_RAM: begin
						if (ram_on_q && cfg.ram_bank_total > 3'd0 &&
								(cfg.ram_size_code > RAM_SIZE_2K ||
								(cfg.ram_size_code == RAM_SIZE_2K && a < 16'hA800))) begin
							rw = 1'b1;
							raddr = {ram_bank_q, off};
							wval = d;
						end
					end
					default: ;
				endcase
			end
			CTL_MBC2: begin
				// Address bit 8 tells the enable register from the ROM bank register.
				case (a[15:13])
					REGION_ENABLE: begin
						if (!a[8])
							ram_on_q = en;
					end
					REGION_ROM_LO: begin
						if (a[8])
							load_rom_bank((d[3:0] == 4'd0) ? 8'd1 : {4'd0, d[3:0]});
					end
					REGION_RAM: begin
						if (a[12:9] == 4'd0 && ram_on_q) begin
							rw = 1'b1;
							raddr = {2'b00, off};
							wval = {4'd0, d[3:0]};
						end
					end
					default: ;
				endcase
			end
			default: begin
				case (a[15:13])
					REGION_ENABLE: ram_on_q = en;
					REGION_ROM_LO: begin
						if (cfg.rom_bank_total > 9'd1)
							load_rom_bank((d[6:0] == 7'd0) ? 8'd1 : {1'b0, d[6:0]});
					end
					REGION_UPPER: begin
						// Values 0 to 3 pick a RAM bank, 8 to 12 an RTC register.
						if (d < 8'h04) begin
							mode_q = MODE_RAM;
							load_ram_bank(d[1:0]);
						end else if (d >= 8'h08 && d < 8'h0D) begin
							mode_q = MODE_RTC;
							rtc_sel_q = d[2:0] - 3'd0;
							rtc_sel_q = 3'(d - 8'h08);
						end
					end
					REGION_RAM: begin
						if (mode_q == MODE_RAM && ram_on_q) begin
							rw = 1'b1;
							raddr = {ram_bank_q, off};
							wval = d;
						end else if (mode_q == MODE_RTC) begin
							tw = 1'b1;
							wval = d;
						end
					end
					default: ;
				endcase
			end
		endcase
		r.rom_bank = rom_bank_q;
		r.ram_bank = ram_bank_q;
		r.ram_on = ram_on_q;
		r.bank_mode = mode_q;
		r.ram_write = rw;
		r.ram_address = raddr;
		r.write_value = wval;
		r.rtc_write = tw;
		r.rtc_index = rtc_sel_q;
		expected_q.push_back(r);
	endfunction

	task report(string what, int unsigned got, int unsigned want);
		mismatches++;
		$display("mismatch on %s at %0t: got 0x%0h, expected 0x%0h", what, $realtime, got, want);
	endtask

	// Compares a result transaction with the oldest prediction, field by field.
	task check_result(cbc_result_t got);
		cbc_result_t want;
		if (expected_q.size() == 0) begin
			report("unexpected result", got.rom_bank, 0);
		end else begin
			want = expected_q.pop_front();
			if (got.rom_bank !== want.rom_bank) report("rom_bank", got.rom_bank, want.rom_bank);
			if (got.ram_bank !== want.ram_bank) report("ram_bank", got.ram_bank, want.ram_bank);
			if (got.ram_on !== want.ram_on) report("ram_on", got.ram_on, want.ram_on);
			if (got.bank_mode !== want.bank_mode)
				report("bank_mode", got.bank_mode, want.bank_mode);
			if (got.ram_write !== want.ram_write)
				report("ram_write", got.ram_write, want.ram_write);
			if (got.ram_address !== want.ram_address)
				report("ram_address", got.ram_address, want.ram_address);
			if (got.write_value !== want.write_value)
				report("write_value", got.write_value, want.write_value);
			if (got.rtc_write !== want.rtc_write)
				report("rtc_write", got.rtc_write, want.rtc_write);
			if (got.rtc_index !== want.rtc_index)
				report("rtc_index", got.rtc_index, want.rtc_index);
		end
	endtask
endclass

module testbench;
	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] bus_address;
	logic [7:0]  bus_data;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  rom_bank;
	logic [1:0]  ram_bank;
	logic        ram_on;
	logic [1:0]  bank_mode;
	logic        ram_write;
	logic [14:0] ram_address;
	logic [7:0]  write_value;
	logic        rtc_write;
	logic [2:0]  rtc_index;

	bank_scoreboard sb;
	int gap_max;
	int hold_off_cycles;

	cartridge_bank_controller dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Overall limit on the run, well above the slowest correct run.
	initial begin
		#400000;
		$display("testbench: errors");
		$finish;
	end

	// Writes one configuration register with a setup and an access cycle.
	task automatic write_register(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.write_register(idx, value);
	endtask

	// Waits for the block to drain, then loads a full register set.
	task automatic configure(ctl_type_t ctl, int rom_total, int ram_total, int size_code);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		write_register(REG_CTL_TYPE, ctl);
		write_register(REG_ROM_TOTAL, rom_total);
		write_register(REG_RAM_TOTAL, ram_total);
		write_register(REG_RAM_SIZE, size_code);
	endtask

	// Offers one write transaction after a random gap and waits until it is taken.
	task automatic send_access(logic [15:0] a, logic [7:0] d);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		bus_address <= a;
		bus_data <= d;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_access(a, d);
	endtask

	// Mostly well-formed accesses to the decoded regions, with some noise.
	task automatic send_random_access();
		logic [15:0] a;
		logic [7:0]  d;
		int region;
		a = 16'($urandom);
		d = 8'($urandom);
		region = $urandom_range(0, 5);
		if ($urandom_range(0, 99) >= 10) begin
			case (region)
				0: begin
					a = 16'($urandom_range(16'h0000, 16'h1FFF));
					if ($urandom_range(0, 1)) d[3:0] = RAM_ENABLE_KEY;
				end
				1: a = 16'($urandom_range(16'h2000, 16'h3FFF));
				2: begin
					a = 16'($urandom_range(16'h4000, 16'h5FFF));
					if ($urandom_range(0, 1)) d = 8'($urandom_range(0, 15));
				end
				3: begin
					a = 16'($urandom_range(16'h6000, 16'h7FFF));
					if ($urandom_range(0, 1)) d = 8'h01;
				end
				4: a = 16'($urandom_range(16'hA000, 16'hA2FF));
				default: begin
					if ($urandom_range(0, 1))
						a = 16'($urandom_range(16'hA700, 16'hA8FF));
					else
						a = 16'($urandom_range(16'hA000, 16'hBFFF));
				end
			endcase
		end
		send_access(a, d);
	endtask

	// Result side: random stalls, one long hold-off on request, and checking.
	initial begin
		int gap;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_cycles > 0) begin
				gap = hold_off_cycles;
				hold_off_cycles = 0;
			end else begin
				gap = $urandom_range(0, gap_max);
			end
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			sb.check_result({rom_bank, ram_bank, ram_on, bank_mode, ram_write,
				ram_address, write_value, rtc_write, rtc_index});
		end
	end

	// Stimulus: reset, directed accesses per controller kind, then random phases.
	initial begin
		ctl_type_t ctl;
		int rom_total;
		int ram_total;
		int size_code;
		sb = new();
		gap_max = 10;
		hold_off_cycles = 0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		bus_address <= '0;
		bus_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: no controller and no RAM, so nothing is stored.
		send_access(16'hA000, 8'hFF);
		// No controller with only 2 KB usable: the edge of the small window.
		configure(CTL_NONE, 0, 0, 1);
		send_access(16'hA7FF, 8'hFF);
		send_access(16'hA800, 8'h00);

		// MBC1: enable key, zero bank, upper bits, RAM mode and the last RAM byte.
		configure(CTL_MBC1, 256, 4, 3);
		send_access(16'h0000, 8'h0A);
		send_access(16'h2000, 8'h00);
		send_access(16'h3FFF, 8'hFF);
		send_access(16'h4000, 8'h03);
		send_access(16'h6000, 8'h01);
		send_access(16'h5FFF, 8'h03);
		send_access(16'hBFFF, 8'hA5);
		send_access(16'h7FFF, 8'h02);
		send_access(16'h1FFF, 8'h1B);

		// MBC2: address bit 8 selects the register, RAM holds nibbles.
		configure(CTL_MBC2, 16, 1, 0);
		send_access(16'h0000, 8'h3A);
		send_access(16'h2100, 8'h00);
		send_access(16'h21FF, 8'h0F);
		send_access(16'h0100, 8'h00);
		send_access(16'hA1FF, 8'hFF);
		send_access(16'hA200, 8'h11);

		// MBC3: largest bank, RTC select and write while disabled, then banked RAM.
		configure(CTL_MBC3, 128, 4, 2);
		send_access(16'h2000, 8'h00);
		send_access(16'h3000, 8'hFF);
		send_access(16'h4000, 8'h0C);
		send_access(16'hB000, 8'h77);
		send_access(16'h4000, 8'h02);
		send_access(16'h0000, 8'h0A);
		send_access(16'hA123, 8'h9C);

		// Random phases, each under its own register settings.
		for (int p = 0; p < 9; p++) begin
			ctl = ctl_type_t'(p % 4);
			case ($urandom_range(0, 5))
				0: rom_total = 0;
				1: rom_total = 1;
				2: rom_total = 2;
				3: rom_total = 256;
				default: rom_total = $urandom_range(3, 255);
			endcase
			ram_total = $urandom_range(0, 4);
			size_code = $urandom_range(0, 3);
			if (p == 0) begin
				rom_total = 0;
				ram_total = 0;
			end else if (p == 1 || p == 3) begin
				rom_total = 256;
				ram_total = 4;
				size_code = 3;
			end
			configure(ctl, rom_total, ram_total, size_code);
			// Some phases run back to back; one of them also holds results back.
			gap_max = (p == 4 || p == 7) ? 0 : 10;
			if (p == 4)
				hold_off_cycles = 300;
			repeat (50) send_random_access();
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule
